@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is held
`define CIDQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check, active during reset too
`define CIDQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/cidq_pkg.sv @@
package cidq_pkg;

    localparam int CIDQ_DEPTH     = 128;
    localparam int CIDQ_WORD_BITS = 32;

    localparam logic [7:0] CAP_RESET = 8'd100;
    localparam logic signed [7:0] FOUND_NONE = -8'sd1;

    localparam logic [3:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [3:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [3:0] REQ_INSERT_AT  = 4'd2;
    localparam logic [3:0] REQ_DELETE_AT  = 4'd3;
    localparam logic [3:0] REQ_READ_AT    = 4'd4;
    localparam logic [3:0] REQ_POP_FRONT  = 4'd5;
    localparam logic [3:0] REQ_POP_BACK   = 4'd6;
    localparam logic [3:0] REQ_CLEAR      = 4'd7;
    localparam logic [3:0] REQ_FIND       = 4'd8;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [7:0]  position;
        logic [31:0] entry_in;
    } t_req;

    typedef struct packed {
        logic               ok;
        logic [31:0]        entry_out;
        logic signed [7:0]  found_pos;
        logic [7:0]         entry_count;
    } t_rsp;

endpackage

@@ rtl/core/cidq_ram.sv @@
module cidq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/circular_indexed_deque_top.sv @@
// Ring-buffer list of words with push/pop at both ends, insert, delete and read at a
// logical position, clear and find. Start a request by raising start while busy is
// low. Push front, push back, clear and every refused request (full, empty, bad
// position, unknown code) answer on the cycle after start. Read at, pop front and pop
// back read one slot. Insert at moves entries from the tail back to position up one
// slot, then writes the word; delete at returns the word at position and moves later
// entries down one slot; find reads from the head and ends early on the first match.
// Walks use the single read port of the slot RAM, one slot per cycle. Each result is
// marked by o_done, high for exactly one cycle; the receiver cannot stall it, so
// capture it on that cycle. A new request may be started on the same cycle that a
// result is shown. Writing capacity_in_use empties the list; write it only while the
// block is idle. Slot contents are not cleared at reset.
module circular_indexed_deque_top
    import cidq_pkg::*;
#(
    parameter int DEPTH     = CIDQ_DEPTH,
    parameter int WORD_BITS = CIDQ_WORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_done,
    output t_rsp       o_rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int XW = (PW + 1 > 9) ? PW + 1 : 9;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] x,
                                               input logic [XW-1:0] c);
        logic [XW-1:0] t;
        t = XW'(x) + XW'(1);
        wrap_inc = (t == c) ? '0 : t[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] x,
                                               input logic [XW-1:0] c);
        logic [XW-1:0] t;
        t = c - XW'(1);
        wrap_dec = (x == '0) ? t[PW-1:0] : x - PW'(1);
    endfunction

    logic [1:0]           r_state, n_state;
    logic [7:0]           r_cap, n_cap;
    logic [PW-1:0]        r_head, n_head;
    logic [PW-1:0]        r_tail, n_tail;
    logic [7:0]           r_count, n_count;
    logic [3:0]           r_op, n_op;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [PW-1:0]        r_wpos, n_wpos;
    logic [PW-1:0]        r_rd_cur, n_rd_cur;
    logic [PW-1:0]        r_wr_cur, n_wr_cur;
    logic [7:0]           r_rd_left, n_rd_left;
    logic [7:0]           r_rd_idx, n_rd_idx;
    logic                 r_dv, n_dv;
    logic [7:0]           r_dv_idx, n_dv_idx;
    logic [31:0]          r_got, n_got;
    logic [7:0]           r_found, n_found;
    logic                 r_fnd, n_fnd;
    logic                 r_done, n_done;
    t_rsp                 r_rsp, n_rsp;

    logic [XW-1:0]        cap;
    logic [XW:0]          pos_sum;
    logic [XW:0]          pos_wrap;
    logic [PW-1:0]        slot_pos;
    logic                 cnt_lt_cap;
    logic [63:0]          word_ext;
    logic [WORD_BITS-1:0] word_in;
    logic [63:0]          rd_ext;

    logic                 mem_we;
    logic [PW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [PW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    always_comb begin
        if (r_cap == 8'd0) begin
            cap = XW'(1);
        end else if (XW'(r_cap) > XW'(DEPTH)) begin
            cap = XW'(DEPTH);
        end else begin
            cap = XW'(r_cap);
        end
    end

    // head + position folded once into the ring, valid while position <= count
    assign pos_sum    = (XW+1)'(r_head) + (XW+1)'(i_req.position);
    assign pos_wrap   = (pos_sum >= (XW+1)'(cap)) ? pos_sum - (XW+1)'(cap) : pos_sum;
    assign slot_pos   = pos_wrap[PW-1:0];
    assign cnt_lt_cap = XW'(r_count) < cap;

    assign word_ext = {32'd0, i_req.entry_in};
    assign word_in  = word_ext[WORD_BITS-1:0];

    always_comb begin
        rd_ext = '0;
        rd_ext[WORD_BITS-1:0] = mem_rdata;
    end

    always_comb begin
        logic imm;
        logic imm_ok;
        imm       = 1'b0;
        imm_ok    = 1'b0;
        n_state   = r_state;
        n_cap     = r_cap;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_op      = r_op;
        n_word    = r_word;
        n_wpos    = r_wpos;
        n_rd_cur  = r_rd_cur;
        n_wr_cur  = r_wr_cur;
        n_rd_left = r_rd_left;
        n_rd_idx  = r_rd_idx;
        n_dv      = 1'b0;
        n_dv_idx  = r_dv_idx;
        n_got     = r_got;
        n_found   = r_found;
        n_fnd     = r_fnd;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_rd_cur;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    imm       = 1'b1;
                    n_op      = i_req.req_type;
                    n_word    = word_in;
                    n_rd_idx  = '0;
                    n_rd_left = '0;
                    n_got     = '0;
                    n_found   = FOUND_NONE;
                    n_fnd     = 1'b0;
                    case (i_req.req_type)
                        REQ_PUSH_FRONT: begin
                            if (cnt_lt_cap) begin
                                n_head    = wrap_dec(r_head, cap);
                                mem_we    = 1'b1;
                                mem_waddr = n_head;
                                mem_wdata = word_in;
                                if (r_count == 8'd0) begin
                                    n_tail = n_head;
                                end
                                n_count = r_count + 8'd1;
                                imm_ok  = 1'b1;
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (cnt_lt_cap) begin
                                n_tail    = wrap_inc(r_tail, cap);
                                mem_we    = 1'b1;
                                mem_waddr = n_tail;
                                mem_wdata = word_in;
                                if (r_count == 8'd0) begin
                                    n_head = n_tail;
                                end
                                n_count = r_count + 8'd1;
                                imm_ok  = 1'b1;
                            end
                        end
                        REQ_INSERT_AT: begin
                            if (cnt_lt_cap && i_req.position <= r_count) begin
                                imm       = 1'b0;
                                n_rd_cur  = r_tail;
                                n_wr_cur  = wrap_inc(r_tail, cap);
                                n_rd_left = r_count - i_req.position;
                                n_count   = r_count + 8'd1;
                                if (r_count == 8'd0) begin
                                    n_head = '0;
                                    n_tail = '0;
                                    n_wpos = '0;
                                end else begin
                                    n_tail = wrap_inc(r_tail, cap);
                                    n_wpos = slot_pos;
                                end
                                n_state = (r_count == i_req.position) ? ST_FIN : ST_WALK;
                            end
                        end
                        REQ_DELETE_AT: begin
                            if (i_req.position < r_count) begin
                                imm       = 1'b0;
                                n_rd_cur  = slot_pos;
                                n_wr_cur  = slot_pos;
                                n_rd_left = r_count - i_req.position;
                                n_count   = r_count - 8'd1;
                                if (r_count == 8'd1) begin
                                    n_head = '0;
                                    n_tail = '0;
                                end else begin
                                    n_tail = wrap_dec(r_tail, cap);
                                end
                                n_state = ST_WALK;
                            end
                        end
                        REQ_READ_AT: begin
                            if (i_req.position < r_count) begin
                                imm       = 1'b0;
                                n_rd_cur  = slot_pos;
                                n_rd_left = 8'd1;
                                n_state   = ST_WALK;
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (r_count != 8'd0) begin
                                imm       = 1'b0;
                                n_rd_cur  = r_head;
                                n_rd_left = 8'd1;
                                n_count   = r_count - 8'd1;
                                n_head    = wrap_inc(r_head, cap);
                                if (r_count == 8'd1) begin
                                    n_tail = n_head;
                                end
                                n_state = ST_WALK;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (r_count != 8'd0) begin
                                imm       = 1'b0;
                                n_rd_cur  = r_tail;
                                n_rd_left = 8'd1;
                                n_count   = r_count - 8'd1;
                                n_tail    = wrap_dec(r_tail, cap);
                                if (r_count == 8'd1) begin
                                    n_head = n_tail;
                                end
                                n_state = ST_WALK;
                            end
                        end
                        REQ_CLEAR: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            imm_ok  = 1'b1;
                        end
                        REQ_FIND: begin
                            if (r_count != 8'd0) begin
                                imm       = 1'b0;
                                n_rd_cur  = r_head;
                                n_rd_left = r_count;
                                n_state   = ST_WALK;
                            end
                        end
                        default: begin
                            imm_ok = 1'b0;
                        end
                    endcase
                    if (imm) begin
                        n_done            = 1'b1;
                        n_rsp.ok          = imm_ok;
                        n_rsp.entry_out   = '0;
                        n_rsp.found_pos   = FOUND_NONE;
                        n_rsp.entry_count = n_count;
                    end
                end
            end
            ST_WALK: begin
                mem_re   = (r_rd_left != 8'd0);
                n_dv     = mem_re;
                n_dv_idx = r_rd_idx;
                if (mem_re) begin
                    n_rd_cur  = (r_op == REQ_INSERT_AT) ? wrap_dec(r_rd_cur, cap)
                                                        : wrap_inc(r_rd_cur, cap);
                    n_rd_left = r_rd_left - 8'd1;
                    n_rd_idx  = r_rd_idx + 8'd1;
                end
                if (r_dv) begin
                    case (r_op)
                        REQ_INSERT_AT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wr_cur;
                            mem_wdata = mem_rdata;
                            n_wr_cur  = wrap_dec(r_wr_cur, cap);
                        end
                        REQ_DELETE_AT: begin
                            if (r_dv_idx == 8'd0) begin
                                n_got = rd_ext[31:0];
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_wr_cur;
                                mem_wdata = mem_rdata;
                                n_wr_cur  = wrap_inc(r_wr_cur, cap);
                            end
                        end
                        REQ_FIND: begin
                            if (mem_rdata == r_word) begin
                                n_fnd   = 1'b1;
                                n_found = r_dv_idx;
                                n_state = ST_FIN;
                            end
                        end
                        default: begin
                            n_got = rd_ext[31:0];
                        end
                    endcase
                    if (r_rd_left == 8'd0) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (r_op == REQ_INSERT_AT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wpos;
                    mem_wdata = r_word;
                end
                n_done            = 1'b1;
                n_rsp.ok          = (r_op == REQ_FIND) ? r_fnd : 1'b1;
                n_rsp.entry_out   = r_got;
                n_rsp.found_pos   = r_found;
                n_rsp.entry_count = r_count;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // capacity write empties the list
        if (i_cfg_we) begin
            n_cap   = i_cfg_data;
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cap     <= CAP_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_rd_left <= '0;
            r_dv      <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap     <= n_cap;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_rd_left <= n_rd_left;
            r_dv      <= n_dv;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_word   <= n_word;
        r_wpos   <= n_wpos;
        r_rd_cur <= n_rd_cur;
        r_wr_cur <= n_wr_cur;
        r_rd_idx <= n_rd_idx;
        r_dv_idx <= n_dv_idx;
        r_got    <= n_got;
        r_found  <= n_found;
        r_fnd    <= n_fnd;
        r_rsp    <= n_rsp;
    end

    cidq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ rtl/core/cidq_checker.sv @@
`include "assert_macros.svh"

module cidq_checker
    import cidq_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input t_req       i_req,
    input logic       o_done,
    input t_rsp       o_rsp
);

    logic       accept;
    logic       r_pend;
    logic [3:0] r_last_type;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_last_type <= REQ_CLEAR;
        end else begin
            if (accept) begin
                r_pend      <= 1'b1;
                r_last_type <= i_req.req_type;
            end else if (o_done) begin
                r_pend <= 1'b0;
            end
        end
    end

    // every result beat belongs to an accepted request
    `CIDQ_ASSERT(a_done_has_req, i_clk, i_rst_n, o_done |-> r_pend, "result without request")

    // end pushes and clear answer on the next cycle
    `CIDQ_ASSERT(a_quick_reply, i_clk, i_rst_n,
        accept && (i_req.req_type == REQ_PUSH_FRONT || i_req.req_type == REQ_PUSH_BACK ||
                   i_req.req_type == REQ_CLEAR) |=> o_done,
        "quick request did not answer next cycle")

    `CIDQ_ASSERT(a_fail_no_word, i_clk, i_rst_n,
        o_done && !o_rsp.ok |-> o_rsp.entry_out == 32'd0, "failed request returned a word")

    `CIDQ_ASSERT(a_pos_only_find, i_clk, i_rst_n,
        o_done && r_last_type != REQ_FIND |-> o_rsp.found_pos == FOUND_NONE,
        "position reported for a request other than find")

    `CIDQ_ASSERT(a_clear_empties, i_clk, i_rst_n,
        o_done && r_last_type == REQ_CLEAR |-> o_rsp.ok && o_rsp.entry_count == 8'd0,
        "clear left entries")

endmodule

bind circular_indexed_deque_top cidq_checker u_cidq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req      (i_req),
    .o_done     (o_done),
    .o_rsp      (o_rsp)
);

@@ bench/testbench.sv @@
module testbench;
    import cidq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    class deque_scoreboard;
        logic [31:0] slots [CIDQ_DEPTH];
        int unsigned head;
        int unsigned tail;
        int unsigned fill;
        int unsigned cap_reg;
        t_rsp pending [$];
        int unsigned fails;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            cap_reg = 32'(CAP_RESET);
            fails = 0;
        endfunction

        function int unsigned ring_size();
            if (cap_reg < 1) begin
                return 1;
            end
            if (cap_reg > CIDQ_DEPTH) begin
                return CIDQ_DEPTH;
            end
            return cap_reg;
        endfunction

        function int unsigned slot_at(int unsigned pos);
            return (head + pos) % ring_size();
        endfunction

        function logic [31:0] word_at(int unsigned pos);
            return slots[slot_at(pos)];
        endfunction

        function void set_capacity(logic [7:0] value);
            cap_reg = 32'(value);
            head = 0;
            tail = 0;
            fill = 0;
        endfunction

        function void note_request(t_req r);
            int unsigned cap;
            int unsigned pos;
            int unsigned i;
            t_rsp e;
            cap = ring_size();
            pos = 32'(r.position);
            e.ok = 1'b0;
            e.entry_out = '0;
            e.found_pos = FOUND_NONE;
            case (r.req_type)
                REQ_PUSH_FRONT: begin
                    if (fill < cap) begin
                        head = (head + cap - 1) % cap;
                        slots[head] = r.entry_in;
                        if (fill == 0) begin
                            tail = head;
                        end
                        fill++;
                        e.ok = 1'b1;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (fill < cap) begin
                        tail = (tail + 1) % cap;
                        slots[tail] = r.entry_in;
                        if (fill == 0) begin
                            head = tail;
                        end
                        fill++;
                        e.ok = 1'b1;
                    end
                end
                REQ_INSERT_AT: begin
                    if (fill < cap && pos <= fill) begin
                        if (fill == 0) begin
                            head = 0;
                            tail = 0;
                        end
                        for (i = fill; i > pos; i--) begin
                            slots[slot_at(i)] = slots[slot_at(i - 1)];
                        end
                        slots[slot_at(pos)] = r.entry_in;
                        fill++;
                        tail = slot_at(fill - 1);
                        e.ok = 1'b1;
                    end
                end
                REQ_DELETE_AT: begin
                    if (pos < fill) begin
                        e.entry_out = slots[slot_at(pos)];
                        for (i = pos; i + 1 < fill; i++) begin
                            slots[slot_at(i)] = slots[slot_at(i + 1)];
                        end
                        fill--;
                        tail = (tail + cap - 1) % cap;
                        if (fill == 0) begin
                            head = 0;
                            tail = 0;
                        end
                        e.ok = 1'b1;
                    end
                end
                REQ_READ_AT: begin
                    if (pos < fill) begin
                        e.entry_out = slots[slot_at(pos)];
                        e.ok = 1'b1;
                    end
                end
                REQ_POP_FRONT: begin
                    if (fill > 0) begin
                        e.entry_out = slots[head % cap];
                        fill--;
                        head = (head + 1) % cap;
                        if (fill == 0) begin
                            tail = head;
                        end
                        e.ok = 1'b1;
                    end
                end
                REQ_POP_BACK: begin
                    if (fill > 0) begin
                        e.entry_out = slots[tail % cap];
                        fill--;
                        tail = (tail + cap - 1) % cap;
                        if (fill == 0) begin
                            head = tail;
                        end
                        e.ok = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    head = 0;
                    tail = 0;
                    fill = 0;
                    e.ok = 1'b1;
                end
                REQ_FIND: begin
                    for (i = 0; i < fill && !e.ok; i++) begin
                        if (slots[slot_at(i)] == r.entry_in) begin
                            e.found_pos = 8'(i);
                            e.ok = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            e.entry_count = 8'(fill);
            pending.push_back(e);
        endfunction

        task report(string what);
            fails++;
            if (fails <= 40) begin
                $display("mismatch: %s", what);
            end
        endtask

        task check_answer(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                report($sformatf("result beat with nothing outstanding, count %0d",
                                 got.entry_count));
                return;
            end
            e = pending.pop_front();
            if (got.ok !== e.ok) begin
                report($sformatf("ok got %b want %b", got.ok, e.ok));
            end
            if (got.entry_out !== e.entry_out) begin
                report($sformatf("entry_out got %h want %h", got.entry_out, e.entry_out));
            end
            if (got.found_pos !== e.found_pos) begin
                report($sformatf("found_pos got %0d want %0d", got.found_pos, e.found_pos));
            end
            if (got.entry_count !== e.entry_count) begin
                report($sformatf("entry_count got %0d want %0d",
                                 got.entry_count, e.entry_count));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req req_bus = '0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;
    logic o_done;
    t_rsp o_rsp;

    deque_scoreboard sb = new();
    int unsigned cycles = 0;
    bit growing = 1'b1;

    circular_indexed_deque_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (req_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                sb.check_answer(o_rsp);
            end
            if (i_cfg_we) begin
                sb.set_capacity(i_cfg_data);
            end
            if (start && !busy) begin
                sb.note_request(req_bus);
            end
        end
    end

    task automatic send(input t_req r);
        start <= 1'b1;
        req_bus <= r;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic direct(input logic [3:0] code, input logic [7:0] pos,
                          input logic [31:0] word);
        t_req r;
        r.req_type = code;
        r.position = pos;
        r.entry_in = word;
        send(r);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_req make_req();
        t_req r;
        int unsigned roll;
        int unsigned n;
        n = sb.fill;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) begin
            r.entry_in = $urandom_range(0, 7);
        end else begin
            r.entry_in = $urandom;
        end
        if (growing) begin
            if (roll < 25) r.req_type = REQ_PUSH_FRONT;
            else if (roll < 50) r.req_type = REQ_PUSH_BACK;
            else if (roll < 70) r.req_type = REQ_INSERT_AT;
            else if (roll < 76) r.req_type = REQ_DELETE_AT;
            else if (roll < 80) r.req_type = REQ_POP_FRONT;
            else if (roll < 84) r.req_type = REQ_POP_BACK;
            else if (roll < 91) r.req_type = REQ_READ_AT;
            else if (roll < 99) r.req_type = REQ_FIND;
            else r.req_type = 4'($urandom_range(9, 15));
        end else begin
            if (roll < 6) r.req_type = REQ_PUSH_FRONT;
            else if (roll < 12) r.req_type = REQ_PUSH_BACK;
            else if (roll < 20) r.req_type = REQ_INSERT_AT;
            else if (roll < 45) r.req_type = REQ_DELETE_AT;
            else if (roll < 60) r.req_type = REQ_POP_FRONT;
            else if (roll < 75) r.req_type = REQ_POP_BACK;
            else if (roll < 85) r.req_type = REQ_READ_AT;
            else if (roll < 97) r.req_type = REQ_FIND;
            else if (roll < 98) r.req_type = REQ_CLEAR;
            else r.req_type = 4'($urandom_range(9, 15));
        end
        if ($urandom_range(0, 9) == 0) begin
            r.position = 8'($urandom_range(0, 255));
        end else if (r.req_type == REQ_INSERT_AT) begin
            r.position = 8'($urandom_range(0, n));
        end else if (r.req_type == REQ_DELETE_AT || r.req_type == REQ_READ_AT) begin
            r.position = (n == 0) ? 8'd0 : 8'($urandom_range(0, n - 1));
        end else begin
            r.position = 8'($urandom_range(0, 255));
        end
        if (r.req_type == REQ_FIND && n > 0 && $urandom_range(0, 1) == 0) begin
            r.entry_in = sb.word_at($urandom_range(0, n - 1));
        end
        return r;
    endfunction

    task automatic run_phase(input logic [7:0] cap, input int unsigned beats,
                             input bit steady);
        int unsigned k;
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        growing = 1'b1;
        for (k = 0; k < beats; k++) begin
            if (sb.fill >= sb.ring_size()) begin
                growing = 1'b0;
            end else if (sb.fill == 0) begin
                growing = 1'b1;
            end
            // drain everything midway through the phase
            if (k == beats / 2) begin
                wait_idle();
            end
            send(make_req());
            if (!steady && $urandom_range(0, 4) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, bad positions, both ends, middle, delete to empty, unknown code, clear
        direct(REQ_POP_FRONT, 8'd0, 32'h0);
        direct(REQ_POP_BACK, 8'd0, 32'h0);
        direct(REQ_DELETE_AT, 8'd0, 32'h0);
        direct(REQ_READ_AT, 8'd0, 32'h0);
        direct(REQ_FIND, 8'd0, 32'h0);
        direct(REQ_INSERT_AT, 8'd1, 32'h1);
        direct(REQ_INSERT_AT, 8'd0, 32'h1111_1111);
        direct(REQ_PUSH_FRONT, 8'd0, 32'hFFFF_FFFF);
        direct(REQ_PUSH_BACK, 8'd255, 32'h0000_0000);
        direct(REQ_INSERT_AT, 8'd3, 32'hA5A5_A5A5);
        direct(REQ_INSERT_AT, 8'd1, 32'h5A5A_5A5A);
        direct(REQ_READ_AT, 8'd0, 32'h0);
        direct(REQ_READ_AT, 8'd4, 32'h0);
        direct(REQ_READ_AT, 8'd255, 32'h0);
        direct(REQ_DELETE_AT, 8'd5, 32'h0);
        direct(REQ_FIND, 8'd0, 32'h0000_0000);
        direct(REQ_FIND, 8'd0, 32'h1234_5678);
        direct(REQ_DELETE_AT, 8'd2, 32'h0);
        direct(REQ_POP_FRONT, 8'd0, 32'h0);
        direct(REQ_POP_BACK, 8'd0, 32'h0);
        direct(REQ_DELETE_AT, 8'd1, 32'h0);
        direct(REQ_DELETE_AT, 8'd0, 32'h0);
        direct(4'd15, 8'd255, 32'hFFFF_FFFF);
        direct(REQ_PUSH_BACK, 8'd0, 32'h0F0F_0F0F);
        direct(REQ_CLEAR, 8'd0, 32'h0);

        run_phase(8'd1, 40, 1'b0);
        run_phase(8'd0, 30, 1'b0);
        run_phase(8'd2, 60, 1'b0);
        run_phase(8'd255, 250, 1'b0);
        run_phase(8'd3, 60, 1'b0);
        run_phase(8'd100, 150, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 150, 1'b0);
        run_phase(8'($urandom_range(1, 16)), 150, 1'b0);
        run_phase(8'd128, 250, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 160, 1'b1);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
